[sv/grdda_pkg.sv]
// grdda_pkg: shared types and constants for the grid ray traversal unit
// no dependencies
package grdda_pkg;
    localparam int MAP_SIDE_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int POS_W   = 22;
    localparam int DIR_W   = 18;
    localparam int DELTA_W = 32;
    localparam int SIDE_W  = 40;
    localparam int DIST_W  = 32;
    localparam int IDX_W   = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // one classified item handed from front to back
    typedef struct packed {
        logic                       is_cast;
        logic [IDX_W-1:0]           cell_x;
        logic [IDX_W-1:0]           cell_y;
        logic                       cell_wall;
        logic [POS_W-1:0]           pos_x;
        logic [POS_W-1:0]           pos_y;
        logic signed [DIR_W-1:0]    dir_x;
        logic signed [DIR_W-1:0]    dir_y;
        logic [DELTA_W-1:0]         delta_x;
        logic [DELTA_W-1:0]         delta_y;
    } grdda_item_t;

    typedef struct packed {
        logic                wall_found;
        logic [IDX_W-1:0]    hit_x;
        logic [IDX_W-1:0]    hit_y;
        logic                hit_side;
        logic [DIST_W-1:0]   perp_distance;
    } grdda_result_t;
endpackage

[sv/grdda_queue.sv]
// grdda_queue: two-entry item queue between front and back
// depends on grdda_pkg
module grdda_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  grdda_pkg::grdda_item_t in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output grdda_pkg::grdda_item_t out_item
);
    import grdda_pkg::*;

    grdda_item_t slot_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !in_ready) else $error("queue overflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count invalid");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue push lost");
endmodule

[sv/grdda_front.sv]
// grdda_front: input register stage that classifies items into write or cast
// depends on grdda_pkg
module grdda_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               valid,
    output logic                               ready,
    input  logic                               operation,
    input  logic [grdda_pkg::IDX_W-1:0]        cell_x,
    input  logic [grdda_pkg::IDX_W-1:0]        cell_y,
    input  logic                               cell_wall,
    input  logic [grdda_pkg::POS_W-1:0]        pos_x,
    input  logic [grdda_pkg::POS_W-1:0]        pos_y,
    input  logic signed [grdda_pkg::DIR_W-1:0] ray_dir_x,
    input  logic signed [grdda_pkg::DIR_W-1:0] ray_dir_y,
    input  logic [grdda_pkg::DELTA_W-1:0]      delta_dist_x,
    input  logic [grdda_pkg::DELTA_W-1:0]      delta_dist_y,
    output logic                               q_valid,
    input  logic                               q_ready,
    output grdda_pkg::grdda_item_t             q_item
);
    import grdda_pkg::*;

    grdda_item_t item_reg;
    logic        full_reg;

    assign ready   = !full_reg || q_ready;
    assign q_valid = full_reg;
    assign q_item  = item_reg;

    always_ff @(posedge clk)
    begin
        if (valid && ready)
        begin
            item_reg.is_cast   <= (operation == OP_CAST);
            item_reg.cell_x    <= cell_x;
            item_reg.cell_y    <= cell_y;
            item_reg.cell_wall <= cell_wall;
            item_reg.pos_x     <= pos_x;
            item_reg.pos_y     <= pos_y;
            item_reg.dir_x     <= ray_dir_x;
            item_reg.dir_y     <= ray_dir_y;
            item_reg.delta_x   <= delta_dist_x;
            item_reg.delta_y   <= delta_dist_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (ready)
        begin
            full_reg <= valid;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !q_ready |=> full_reg && $stable(item_reg))
        else $error("front item dropped");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !full_reg |-> ready) else $error("front stalls while empty");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready |=> full_reg) else $error("front lost accept");
endmodule

[sv/grdda_back.sv]
// grdda_back: map memory, dda walk, serial divider and output register
// depends on grdda_pkg
module grdda_back #(
    parameter int MAP_SIDE  = grdda_pkg::MAP_SIDE_DEF,
    parameter int FRAC_BITS = grdda_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  grdda_pkg::grdda_item_t q_item,
    output logic                   res_valid,
    input  logic                   res_ready,
    output grdda_pkg::grdda_result_t res
);
    import grdda_pkg::*;

    localparam int MI_W    = $clog2(MAP_SIDE);
    localparam int DEPTH   = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W  = 2 * MI_W;
    localparam int WK_W    = MI_W + 1;
    localparam int IPOS_W  = POS_W - FRAC_BITS;
    localparam int NUM_W   = POS_W + 2;
    localparam int QW      = NUM_W + FRAC_BITS;
    localparam int DCNT_W  = $clog2(QW + 1);
    localparam int PROD_W  = FRAC_BITS + 1 + DELTA_W;
    localparam logic [SIDE_W-1:0] SIDE_MAX = '1;
    localparam logic [FRAC_BITS:0] FIX_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_MUL, S_STEP, S_READ, S_TEST, S_DIV, S_DONE
    } state_t;

    state_t               state_reg;
    logic [ADDR_W:0]      clr_reg;
    logic                 mem [DEPTH];
    logic                 rd_reg;
    logic [ADDR_W-1:0]    rd_addr;
    grdda_item_t          it_reg;
    logic signed [WK_W:0] wx_reg, wy_reg;
    logic [SIDE_W-1:0]    sx_reg, sy_reg;
    logic                 side_reg;
    logic [QW-1:0]        dv_num_reg;
    logic [DIR_W-1:0]     dv_den_reg;
    logic [DIR_W:0]       dv_rem_reg;
    logic [DCNT_W-1:0]    dv_cnt_reg;
    logic                 res_valid_reg;
    grdda_result_t        res_reg;

    logic                 neg_x, neg_y;
    logic [FRAC_BITS:0]   part_x, part_y;
    logic [PROD_W-1:0]    prod_x, prod_y;
    logic [SIDE_W:0]      sum_x, sum_y;
    logic signed [WK_W:0] nx, ny;
    logic                 nx_out;
    logic [IPOS_W-1:0]    ipx, ipy;
    logic signed [NUM_W:0] cell_fix, pos_fix, diff;
    logic signed [DIR_W:0] dsel;
    logic [DIR_W:0]       rem_sh, rem_sub;

    assign neg_x = it_reg.dir_x[DIR_W-1];
    assign neg_y = it_reg.dir_y[DIR_W-1];
    assign part_x = neg_x ? {1'b0, it_reg.pos_x[FRAC_BITS-1:0]}
                          : FIX_ONE - {1'b0, it_reg.pos_x[FRAC_BITS-1:0]};
    assign part_y = neg_y ? {1'b0, it_reg.pos_y[FRAC_BITS-1:0]}
                          : FIX_ONE - {1'b0, it_reg.pos_y[FRAC_BITS-1:0]};
    assign prod_x = PROD_W'(part_x) * PROD_W'(it_reg.delta_x);
    assign prod_y = PROD_W'(part_y) * PROD_W'(it_reg.delta_y);
    assign sum_x = {1'b0, sx_reg} + (SIDE_W+1)'(it_reg.delta_x);
    assign sum_y = {1'b0, sy_reg} + (SIDE_W+1)'(it_reg.delta_y);
    assign ipx = it_reg.pos_x[POS_W-1:FRAC_BITS];
    assign ipy = it_reg.pos_y[POS_W-1:FRAC_BITS];

    // next cell after one dda step, ties go to y
    always_comb
    begin
        nx = wx_reg;
        ny = wy_reg;
        if (sx_reg < sy_reg)
            nx = neg_x ? wx_reg - 2'sd1 : wx_reg + 2'sd1;
        else
            ny = neg_y ? wy_reg - 2'sd1 : wy_reg + 2'sd1;
        nx_out = (nx < 0) || (nx >= (WK_W+1)'(MAP_SIDE)) ||
                 (ny < 0) || (ny >= (WK_W+1)'(MAP_SIDE));
    end

    assign rd_addr = {wx_reg[MI_W-1:0], wy_reg[MI_W-1:0]};

    // numerator and divisor for the crossed axis
    always_comb
    begin
        if (!side_reg)
        begin
            cell_fix = (NUM_W+1)'(wx_reg + (neg_x ? 2'sd1 : 2'sd0)) <<< FRAC_BITS;
            pos_fix  = (NUM_W+1)'({1'b0, it_reg.pos_x});
            dsel     = (DIR_W+1)'(it_reg.dir_x);
        end
        else
        begin
            cell_fix = (NUM_W+1)'(wy_reg + (neg_y ? 2'sd1 : 2'sd0)) <<< FRAC_BITS;
            pos_fix  = (NUM_W+1)'({1'b0, it_reg.pos_y});
            dsel     = (DIR_W+1)'(it_reg.dir_y);
        end
        diff = cell_fix - pos_fix;
    end

    assign rem_sh  = {dv_rem_reg[DIR_W-1:0], dv_num_reg[QW-1]};
    assign rem_sub = rem_sh - {1'b0, dv_den_reg};

    assign q_ready   = (state_reg == S_IDLE) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            mem[clr_reg[ADDR_W-1:0]] <= 1'b0;
        else if (q_valid && q_ready && !q_item.is_cast &&
                 32'(q_item.cell_x) < MAP_SIDE && 32'(q_item.cell_y) < MAP_SIDE)
            mem[{q_item.cell_x[MI_W-1:0], q_item.cell_y[MI_W-1:0]}] <= q_item.cell_wall;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            it_reg        <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            side_reg      <= 1'b0;
            dv_num_reg    <= '0;
            dv_den_reg    <= '0;
            dv_rem_reg    <= '0;
            dv_cnt_reg    <= '0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (ADDR_W+1)'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        it_reg <= q_item;
                        wx_reg <= (WK_W+1)'(q_item.pos_x[POS_W-1:FRAC_BITS]);
                        wy_reg <= (WK_W+1)'(q_item.pos_y[POS_W-1:FRAC_BITS]);
                        if (!q_item.is_cast)
                        begin
                            res_reg       <= '0;
                            res_valid_reg <= 1'b1;
                        end
                        else
                            state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (32'(ipx) >= MAP_SIDE || 32'(ipy) >= MAP_SIDE)
                    begin
                        res_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        sx_reg <= (prod_x[PROD_W-1:FRAC_BITS] > PROD_W'(SIDE_MAX)) ? SIDE_MAX
                                  : SIDE_W'(prod_x[PROD_W-1:FRAC_BITS]);
                        sy_reg <= (prod_y[PROD_W-1:FRAC_BITS] > PROD_W'(SIDE_MAX)) ? SIDE_MAX
                                  : SIDE_W'(prod_y[PROD_W-1:FRAC_BITS]);
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (sx_reg < sy_reg)
                    begin
                        sx_reg   <= sum_x[SIDE_W] ? SIDE_MAX : sum_x[SIDE_W-1:0];
                        side_reg <= 1'b0;
                    end
                    else
                    begin
                        sy_reg   <= sum_y[SIDE_W] ? SIDE_MAX : sum_y[SIDE_W-1:0];
                        side_reg <= 1'b1;
                    end
                    wx_reg <= nx;
                    wy_reg <= ny;
                    if (nx_out)
                    begin
                        res_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_READ;
                end
                S_READ:
                    state_reg <= S_TEST;
                S_TEST:
                begin
                    if (rd_reg)
                    begin
                        dv_num_reg <= QW'(diff < 0 ? -diff : diff) << FRAC_BITS;
                        dv_den_reg <= DIR_W'(dsel < 0 ? -dsel : dsel);
                        dv_rem_reg <= '0;
                        dv_cnt_reg <= '0;
                        state_reg  <= S_DIV;
                    end
                    else
                        state_reg <= S_STEP;
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    if (rem_sub[DIR_W])
                    begin
                        dv_rem_reg <= rem_sh;
                        dv_num_reg <= {dv_num_reg[QW-2:0], 1'b0};
                    end
                    else
                    begin
                        dv_rem_reg <= rem_sub;
                        dv_num_reg <= {dv_num_reg[QW-2:0], 1'b1};
                    end
                    dv_cnt_reg <= dv_cnt_reg + 1'b1;
                    if (dv_cnt_reg == DCNT_W'(QW - 1))
                    begin
                        res_reg.wall_found <= 1'b1;
                        res_reg.hit_x      <= IDX_W'(wx_reg);
                        res_reg.hit_y      <= IDX_W'(wy_reg);
                        res_reg.hit_side   <= side_reg;
                        if (dv_den_reg == '0 ||
                            {dv_num_reg[QW-2:0], ~rem_sub[DIR_W]} > QW'(32'hFFFF_FFFF))
                            res_reg.perp_distance <= '1;
                        else
                            res_reg.perp_distance <= DIST_W'({dv_num_reg[QW-2:0],
                                                              ~rem_sub[DIR_W]});
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    res_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |=> res_valid_reg && $stable(res_reg))
        else $error("result overwritten");
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> !res_valid_reg)
        else $error("done while blocked");
    a_walk_in: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> wx_reg >= 0 && wy_reg >= 0)
        else $error("walk read outside grid");
endmodule

[sv/grid_ray_dda_traversal_unit.sv]
// grid_ray_dda_traversal_unit: top level of the grid ray traversal unit
// depends on grdda_pkg, grdda_front, grdda_queue, grdda_back
//
//   channel   direction  handshake           payload
//   input     in         valid / ready       operation .. delta_dist_y
//   result    out        out_valid / out_ready  wall_found .. perp_distance
//
// an item passes the front register and the queue to the back end, which registers a
// write result directly; a cast passes S_MUL, then S_STEP, S_READ and S_TEST per cell
// stepped, the serial divide (one quotient bit a cycle) and S_DONE; the back end
// takes a new item only in S_IDLE, and its walk reads the map memory once per step
// after reset a clearing pass zeroes all MAP_SIDE*MAP_SIDE (4096) map cells, and the
// back end takes no item meanwhile; the front register and the two-entry queue hold
// up to three items so input and result sides stall independently
module grid_ray_dda_traversal_unit #(
    parameter int MAP_SIDE  = grdda_pkg::MAP_SIDE_DEF,
    parameter int FRAC_BITS = grdda_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               valid,
    output logic                               ready,
    input  logic                               operation,
    input  logic [grdda_pkg::IDX_W-1:0]        cell_x,
    input  logic [grdda_pkg::IDX_W-1:0]        cell_y,
    input  logic                               cell_wall,
    input  logic [grdda_pkg::POS_W-1:0]        pos_x,
    input  logic [grdda_pkg::POS_W-1:0]        pos_y,
    input  logic signed [grdda_pkg::DIR_W-1:0] ray_dir_x,
    input  logic signed [grdda_pkg::DIR_W-1:0] ray_dir_y,
    input  logic [grdda_pkg::DELTA_W-1:0]      delta_dist_x,
    input  logic [grdda_pkg::DELTA_W-1:0]      delta_dist_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               wall_found,
    output logic [grdda_pkg::IDX_W-1:0]        hit_x,
    output logic [grdda_pkg::IDX_W-1:0]        hit_y,
    output logic                               hit_side,
    output logic [grdda_pkg::DIST_W-1:0]       perp_distance
);
    import grdda_pkg::*;

    // front stage to queue
    logic          f_valid, f_ready;
    grdda_item_t   f_item;
    // queue to back end
    logic          b_valid, b_ready;
    grdda_item_t   b_item;
    grdda_result_t res;

    grdda_front u_front (
        .clk, .rst_n, .valid, .ready, .operation, .cell_x, .cell_y, .cell_wall,
        .pos_x, .pos_y, .ray_dir_x, .ray_dir_y, .delta_dist_x, .delta_dist_y,
        .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
    );

    grdda_queue u_queue (
        .clk, .rst_n,
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
    );

    grdda_back #(.MAP_SIDE(MAP_SIDE), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n,
        .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
        .res_valid(out_valid), .res_ready(out_ready), .res(res)
    );

    // unpack the result transaction onto the output ports
    assign wall_found    = res.wall_found;
    assign hit_x         = res.hit_x;
    assign hit_y         = res.hit_y;
    assign hit_side      = res.hit_side;
    assign perp_distance = res.perp_distance;

    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !wall_found |-> perp_distance == '0 && !hit_side)
        else $error("miss result not cleared");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(perp_distance))
        else $error("result dropped");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid) else $error("input valid withdrawn");
endmodule
